// ----- rtl/bcps_pkg.sv -----
// Shared types, codes and defaults for the Bezier curve point stepper.
`timescale 1ns / 1ps

package bcps_pkg;

  // Default widths of a map coordinate and of the curve parameter fraction.
  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CTRL_COUNT = 3'd0,
    CFG_CTRL_A_X   = 3'd1,
    CFG_CTRL_A_Y   = 3'd2,
    CFG_CTRL_B_X   = 3'd3,
    CFG_CTRL_B_Y   = 3'd4,
    CFG_STEP_SIZE  = 3'd5
  } cfg_idx_e;

  // Input function codes.
  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_e;

  // Curve order, derived from the number of inner control points.
  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_QUAD   = 2'd1,
    MODE_CUBIC  = 2'd2
  } mode_e;

  // Multiplier operand A selection.
  typedef enum logic [2:0] {
    A_U  = 3'd0,
    A_T  = 3'd1,
    A_W0 = 3'd2,
    A_W1 = 3'd3,
    A_W2 = 3'd4
  } a_sel_e;

  // Multiplier operand B selection, per coordinate lane.
  typedef enum logic [2:0] {
    B_U  = 3'd0,
    B_T  = 3'd1,
    B_P0 = 3'd2,
    B_PA = 3'd3,
    B_PB = 3'd4,
    B_P3 = 3'd5,
    B_Q0 = 3'd6,
    B_Q1 = 3'd7
  } b_sel_e;

  // What happens to a product in the cycle after it is issued.
  typedef enum logic [3:0] {
    ACC_NONE    = 4'd0,
    ACC_LOAD    = 4'd1,
    ACC_ADD     = 4'd2,
    ACC_ADD_Q0  = 4'd3,
    ACC_ADD_Q1  = 4'd4,
    ACC_ADD_RES = 4'd5,
    ACC_W0_LOAD = 4'd6,
    ACC_W1_LOAD = 4'd7,
    ACC_W2_LOAD = 4'd8
  } acc_op_e;

  typedef enum logic [3:0] {
    S_IDLE    = 4'd0,
    S_W_UU    = 4'd1,
    S_W_UT    = 4'd2,
    S_W_TT    = 4'd3,
    S_Q0_0    = 4'd4,
    S_Q0_1    = 4'd5,
    S_Q0_2    = 4'd6,
    S_Q1_0    = 4'd7,
    S_Q1_1    = 4'd8,
    S_Q1_2    = 4'd9,
    S_FIN_U   = 4'd10,
    S_FIN_T   = 4'd11,
    S_DRAIN   = 4'd12,
    S_DELIVER = 4'd13
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_curve;
    logic    advance;
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
  } bcps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  curve_active;
    mode_e mode;
  } bcps_sts_t;

  function automatic mode_e count_to_mode(input logic [1:0] count);
    mode_e m;
    case (count)
      2'd0:    m = MODE_LINEAR;
      2'd1:    m = MODE_QUAD;
      default: m = MODE_CUBIC;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/bezier_curve_point_stepper.sv -----
// Top level of the Bezier curve point stepper.
`timescale 1ns / 1ps

// Usage:
// The input channel carries one transaction per item: func_i low starts a new curve from
// start_x_i/start_y_i to end_x_i/end_y_i, func_i high asks for the next point. The output
// channel carries one transaction per point: point_x_o, point_y_o and last_o, which is high
// on the final point of the curve. Both channels move a transaction at a clock edge where
// valid is high and stall is low. Configuration (curve order, inner control points and the
// parameter step) is written through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
// Sequence: a start transaction, and an advance with no curve armed, give no output. An
// advance for a linear, quadratic or cubic curve runs through the accepting cycle, the 2, 6
// or 11 products that the two-lane multiplier (one lane for x, one for y) must issue in turn,
// a drain step and a hand-off step, after which the point is in the output register.
// A finished point moves into the output register, so the next item is accepted
// while the previous point still waits on a stalled receiver; the new point is then held
// inside until the output register is free.
// Reset puts the registers at their defaults (step size seven), disarms the curve and
// empties the output register.
module bezier_curve_point_stepper #(
  parameter int unsigned COORD_BITS = bcps_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = bcps_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [COORD_BITS-1:0]          start_x_i,
  input  logic [COORD_BITS-1:0]          start_y_i,
  input  logic [COORD_BITS-1:0]          end_x_i,
  input  logic [COORD_BITS-1:0]          end_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [COORD_BITS-1:0]          point_x_o,
  output logic [COORD_BITS-1:0]          point_y_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [bcps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [((COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS)-1:0] cfg_data_i
);
  import bcps_pkg::*;

  bcps_cmd_t cmd;
  bcps_sts_t sts;

  // The controller owns the handshakes and the step sequence of each point.
  bcps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds configuration, the curve state and the multiply-accumulate lanes.
  bcps_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .point_x_o  (point_x_o),
    .point_y_o  (point_y_o),
    .last_o     (last_o)
  );

  // A point is handed to the output register only while a curve is armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.advance |-> sts.curve_active)
    else $error("point delivered with no armed curve");

  // After a hand-off the output is valid and the last flag matches the disarmed curve.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.advance |=> (out_valid_o && (last_o == !sts.curve_active)))
    else $error("last flag disagrees with curve state");

  // Items that give no point leave the block ready for the next transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && ((func_i == FUNC_START) || !sts.curve_active))
      |=> !in_stall_o)
    else $error("block busy after an item without a point");

endmodule

// ----- rtl/bcps_datapath.sv -----
// Datapath: configuration, curve state and the two-lane multiply-accumulate unit.
`timescale 1ns / 1ps

module bcps_datapath #(
  parameter int unsigned COORD_BITS = bcps_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = bcps_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bcps_pkg::bcps_cmd_t                  cmd_i,
  output bcps_pkg::bcps_sts_t                  sts_o,
  input  logic                                 cfg_we_i,
  input  logic [bcps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [((COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS)-1:0] cfg_data_i,
  input  logic [COORD_BITS-1:0]                start_x_i,
  input  logic [COORD_BITS-1:0]                start_y_i,
  input  logic [COORD_BITS-1:0]                end_x_i,
  input  logic [COORD_BITS-1:0]                end_y_i,
  output logic [COORD_BITS-1:0]                point_x_o,
  output logic [COORD_BITS-1:0]                point_y_o,
  output logic                                 last_o
);
  import bcps_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned U_W   = F + 1;
  localparam int unsigned W_W   = 2 * F + 1;
  localparam int unsigned Q_W   = F + C;
  localparam int unsigned ACC_W = 2 * F + C;
  localparam int unsigned MA_W  = W_W;
  localparam int unsigned MB_W  = Q_W;
  localparam int unsigned P_W   = MA_W + MB_W;
  localparam int unsigned LANES = 2;

  logic [1:0]       ctrl_count_q;
  logic [C-1:0]     ctrl_a_q [LANES];
  logic [C-1:0]     ctrl_b_q [LANES];
  logic [F-1:0]     step_size_q;
  logic [F-1:0]     param_t_q;
  logic             active_q;
  logic [C-1:0]     first_q  [LANES];
  logic [C-1:0]     final_q  [LANES];

  logic [W_W-1:0]   w0_q, w1_q, w2_q;
  logic [Q_W-1:0]   q0_q     [LANES];
  logic [Q_W-1:0]   q1_q     [LANES];
  logic [ACC_W-1:0] acc_q    [LANES];
  logic [ACC_W-1:0] prod_q   [LANES];
  logic [ACC_W-1:0] prod_d   [LANES];
  logic [C-1:0]     res_q    [LANES];
  logic [C-1:0]     pt_q     [LANES];
  logic             last_q;
  acc_op_e          op2_q;

  logic [U_W-1:0]   u_w;
  logic [F-1:0]     step_w;
  logic [F:0]       next_t_w;
  logic             last_w;
  mode_e            mode_w;
  logic [MA_W-1:0]  opa_w;
  logic [MB_W-1:0]  opb_w    [LANES];
  logic [P_W-1:0]   mul_w    [LANES];
  logic [ACC_W-1:0] sum_w    [LANES];
  logic [ACC_W-1:0] shifted_w[LANES];
  logic [C-1:0]     clamp_w  [LANES];

  assign mode_w   = count_to_mode(ctrl_count_q);
  assign u_w      = {1'b1, {F{1'b0}}} - {1'b0, param_t_q};
  assign step_w   = (step_size_q == '0) ? {{(F-1){1'b0}}, 1'b1} : step_size_q;
  assign next_t_w = {1'b0, param_t_q} + {1'b0, step_w};
  assign last_w   = next_t_w[F];

  assign sts_o.curve_active = active_q;
  assign sts_o.mode         = mode_w;

  always_comb begin
    case (cmd_i.a_sel)
      A_U:     opa_w = MA_W'(u_w);
      A_T:     opa_w = MA_W'(param_t_q);
      A_W0:    opa_w = w0_q;
      A_W1:    opa_w = w1_q;
      A_W2:    opa_w = w2_q;
      default: opa_w = '0;
    endcase
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      case (cmd_i.b_sel)
        B_U:     opb_w[l] = MB_W'(u_w);
        B_T:     opb_w[l] = MB_W'(param_t_q);
        B_P0:    opb_w[l] = MB_W'(first_q[l]);
        B_PA:    opb_w[l] = MB_W'(ctrl_a_q[l]);
        B_PB:    opb_w[l] = MB_W'(ctrl_b_q[l]);
        B_P3:    opb_w[l] = MB_W'(final_q[l]);
        B_Q0:    opb_w[l] = q0_q[l];
        B_Q1:    opb_w[l] = q1_q[l];
        default: opb_w[l] = '0;
      endcase
      mul_w[l]  = P_W'(opa_w) * P_W'(opb_w[l]);
      prod_d[l] = mul_w[l][ACC_W-1:0];
      sum_w[l]  = acc_q[l] + prod_q[l];
      // The quadratic sum is shifted down by both parameter scalings, the others by only one.
      shifted_w[l] = (mode_w == MODE_QUAD) ? (sum_w[l] >> (2 * F)) : (sum_w[l] >> F);
      clamp_w[l]   = (|shifted_w[l][ACC_W-1:C]) ? {C{1'b1}} : shifted_w[l][C-1:0];
    end
  end

  // Configuration, curve state and pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_count_q <= '0;
      ctrl_a_q     <= '{default: '0};
      ctrl_b_q     <= '{default: '0};
      step_size_q  <= F'(7);
      param_t_q    <= '0;
      active_q     <= 1'b0;
      first_q      <= '{default: '0};
      final_q      <= '{default: '0};
      op2_q        <= ACC_NONE;
    end else begin
      op2_q <= cmd_i.acc_op;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CTRL_COUNT: ctrl_count_q <= cfg_data_i[1:0];
          CFG_CTRL_A_X:   ctrl_a_q[0]  <= cfg_data_i[C-1:0];
          CFG_CTRL_A_Y:   ctrl_a_q[1]  <= cfg_data_i[C-1:0];
          CFG_CTRL_B_X:   ctrl_b_q[0]  <= cfg_data_i[C-1:0];
          CFG_CTRL_B_Y:   ctrl_b_q[1]  <= cfg_data_i[C-1:0];
          CFG_STEP_SIZE:  step_size_q  <= cfg_data_i[F-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load_curve) begin
        first_q[0] <= start_x_i;
        first_q[1] <= start_y_i;
        final_q[0] <= end_x_i;
        final_q[1] <= end_y_i;
        param_t_q  <= '0;
        active_q   <= 1'b1;
      end else if (cmd_i.advance) begin
        param_t_q <= last_w ? '0 : next_t_w[F-1:0];
        active_q  <= !last_w;
      end
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (op2_q)
      ACC_W0_LOAD: w0_q <= prod_q[0][W_W-1:0];
      ACC_W1_LOAD: w1_q <= {prod_q[0][W_W-2:0], 1'b0};
      ACC_W2_LOAD: w2_q <= prod_q[0][W_W-1:0];
      default: ;
    endcase
    for (int l = 0; l < LANES; l++) begin
      case (op2_q)
        ACC_LOAD:    acc_q[l] <= prod_q[l];
        ACC_ADD:     acc_q[l] <= sum_w[l];
        ACC_ADD_Q0:  q0_q[l]  <= sum_w[l][ACC_W-1:F];
        ACC_ADD_Q1:  q1_q[l]  <= sum_w[l][ACC_W-1:F];
        ACC_ADD_RES: res_q[l] <= clamp_w[l];
        default: ;
      endcase
    end
    if (cmd_i.advance) begin
      pt_q   <= res_q;
      last_q <= last_w;
    end
  end

  assign point_x_o = pt_q[0];
  assign point_y_o = pt_q[1];
  assign last_o    = last_q;

endmodule

// ----- rtl/bcps_ctrl.sv -----
// Controller: sequences the multiply steps of one point and runs both handshakes.
`timescale 1ns / 1ps

module bcps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                func_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  bcps_pkg::bcps_sts_t sts_i,
  output bcps_pkg::bcps_cmd_t cmd_o
);
  import bcps_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   cubic_w, linear_w;

  assign cubic_w  = (sts_i.mode == MODE_CUBIC);
  assign linear_w = (sts_i.mode == MODE_LINEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o.load_curve  = 1'b0;
    cmd_o.advance     = 1'b0;
    cmd_o.a_sel       = A_U;
    cmd_o.b_sel       = B_U;
    cmd_o.acc_op      = ACC_NONE;
    in_stall_o        = 1'b1;
    out_valid_d       = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (func_i == FUNC_START) begin
            cmd_o.load_curve = 1'b1;
          end else if (sts_i.curve_active) begin
            state_d = linear_w ? S_FIN_U : S_W_UU;
          end
        end
      end
      S_W_UU: begin
        cmd_o.acc_op = ACC_W0_LOAD;
        state_d      = S_W_UT;
      end
      S_W_UT: begin
        cmd_o.b_sel  = B_T;
        cmd_o.acc_op = ACC_W1_LOAD;
        state_d      = S_W_TT;
      end
      S_W_TT: begin
        cmd_o.a_sel  = A_T;
        cmd_o.b_sel  = B_T;
        cmd_o.acc_op = ACC_W2_LOAD;
        state_d      = S_Q0_0;
      end
      S_Q0_0: begin
        cmd_o.a_sel  = A_W0;
        cmd_o.b_sel  = B_P0;
        cmd_o.acc_op = ACC_LOAD;
        state_d      = S_Q0_1;
      end
      S_Q0_1: begin
        cmd_o.a_sel  = A_W1;
        cmd_o.b_sel  = B_PA;
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_Q0_2;
      end
      S_Q0_2: begin
        cmd_o.a_sel  = A_W2;
        cmd_o.b_sel  = cubic_w ? B_PB : B_P3;
        cmd_o.acc_op = cubic_w ? ACC_ADD_Q0 : ACC_ADD_RES;
        state_d      = cubic_w ? S_Q1_0 : S_DRAIN;
      end
      S_Q1_0: begin
        cmd_o.a_sel  = A_W0;
        cmd_o.b_sel  = B_PA;
        cmd_o.acc_op = ACC_LOAD;
        state_d      = S_Q1_1;
      end
      S_Q1_1: begin
        cmd_o.a_sel  = A_W1;
        cmd_o.b_sel  = B_PB;
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_Q1_2;
      end
      S_Q1_2: begin
        cmd_o.a_sel  = A_W2;
        cmd_o.b_sel  = B_P3;
        cmd_o.acc_op = ACC_ADD_Q1;
        state_d      = S_FIN_U;
      end
      S_FIN_U: begin
        cmd_o.a_sel  = A_U;
        cmd_o.b_sel  = linear_w ? B_P0 : B_Q0;
        cmd_o.acc_op = ACC_LOAD;
        state_d      = S_FIN_T;
      end
      S_FIN_T: begin
        cmd_o.a_sel  = A_T;
        cmd_o.b_sel  = linear_w ? B_P3 : B_Q1;
        cmd_o.acc_op = ACC_ADD_RES;
        state_d      = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_DELIVER;
      end
      S_DELIVER: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.advance = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- tb/sv/bezier_curve_point_stepper_tb.sv -----
// Self-checking testbench for the Bezier curve point stepper.
`timescale 1ns / 1ps

module bezier_curve_point_stepper_tb;
  import bcps_pkg::*;

  localparam int unsigned CW = COORD_BITS_DEF;
  localparam int unsigned FW = FRAC_BITS_DEF;
  localparam int unsigned DW = (CW > FW) ? CW : FW;
  localparam logic [63:0] T_ONE = 64'd1 << FW;
  localparam logic [CW-1:0] COORD_MAX = '1;
  // Settling time after the last owed point, with a margin over the slowest (cubic) point.
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam longint unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_ADVANCES = 48;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } point_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic          func_i = 1'b0;
  logic [CW-1:0] start_x_i = '0;
  logic [CW-1:0] start_y_i = '0;
  logic [CW-1:0] end_x_i = '0;
  logic [CW-1:0] end_y_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [CW-1:0] point_x_o;
  logic [CW-1:0] point_y_o;
  logic          last_o;
  logic          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DW-1:0] cfg_data_i = '0;

  // Mirror of the block's registers and curve state, as seen at transaction boundaries.
  logic [1:0]    reg_ctrl_count = 2'd0;
  logic [CW-1:0] ctrl_ax = '0, ctrl_ay = '0, ctrl_bx = '0, ctrl_by = '0;
  logic [FW-1:0] reg_step = FW'(7);
  logic [FW-1:0] curve_t = '0;
  logic          curve_armed = 1'b0;
  logic [CW-1:0] from_x = '0, from_y = '0, to_x = '0, to_y = '0;

  // Points that the block still owes, oldest first.
  point_t pending_points[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned useful_items = 0;
  int unsigned items_in = 0;
  int unsigned results_out = 0;
  int unsigned curve_ends = 0;
  int unsigned cfg_writes = 0;
  longint unsigned cycle_count = 0;

  bezier_curve_point_stepper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d points outstanding.", cycle_count,
               pending_points.size());
      $display("** bezier_curve_point_stepper: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here once requested.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Weighted sum of three control values with Bernstein weights u^2, 2ut, t^2.
  function automatic logic [63:0] blend3(input logic [63:0] p0, p1, p2, t, u);
    return u * u * p0 + 64'd2 * u * t * p1 + t * t * p2;
  endfunction

  function automatic logic [CW-1:0] curve_coord(input logic [CW-1:0] p0, pa, pb, p3,
                                                input logic [FW-1:0] t);
    logic [63:0] tt, u, v, q0, q1;
    mode_e       m;
    tt = 64'(t);
    u  = T_ONE - tt;
    case (reg_ctrl_count)
      2'd0:    m = MODE_LINEAR;
      2'd1:    m = MODE_QUAD;
      default: m = MODE_CUBIC;
    endcase
    case (m)
      MODE_LINEAR: v = (u * 64'(p0) + tt * 64'(p3)) >> FW;
      MODE_QUAD:   v = blend3(64'(p0), 64'(pa), 64'(p3), tt, u) >> (2 * FW);
      default: begin
        // Cubic as a linear blend of two quadratics, each truncated to the parameter scale.
        q0 = blend3(64'(p0), 64'(pa), 64'(pb), tt, u) >> FW;
        q1 = blend3(64'(pa), 64'(pb), 64'(p3), tt, u) >> FW;
        v  = (u * q0 + tt * q1) >> FW;
      end
    endcase
    if (v > 64'(COORD_MAX)) v = 64'(COORD_MAX);
    return v[CW-1:0];
  endfunction

  // Updates the mirrored state for one accepted transaction and queues its point, if any.
  function automatic void predict_item(input func_e f, input logic [CW-1:0] sx, sy, ex, ey);
    logic [63:0]   next_t;
    logic [FW-1:0] inc;
    point_t        p;
    if (f == FUNC_START) begin
      from_x = sx;
      from_y = sy;
      to_x = ex;
      to_y = ey;
      curve_t = '0;
      curve_armed = 1'b1;
      useful_items++;
    end else if (curve_armed) begin
      p.x = curve_coord(from_x, ctrl_ax, ctrl_bx, to_x, curve_t);
      p.y = curve_coord(from_y, ctrl_ay, ctrl_by, to_y, curve_t);
      inc = (reg_step == '0) ? FW'(1) : reg_step;
      next_t = 64'(curve_t) + 64'(inc);
      if (next_t >= T_ONE) begin
        p.last = 1'b1;
        curve_t = '0;
        curve_armed = 1'b0;
      end else begin
        p.last = 1'b0;
        curve_t = next_t[FW-1:0];
      end
      pending_points = {pending_points, p};
      useful_items++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [CW-1:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Each output transaction is matched against the oldest owed point.
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point (%0d, %0d) last=%0b", point_x_o, point_y_o, last_o);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        check_field("point_x", want.x, point_x_o);
        check_field("point_y", want.y, point_y_o);
        check_field("last", CW'(want.last), CW'(last_o));
        results_out++;
        if (want.last) curve_ends++;
      end
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return '0;
      1:       return COORD_MAX;
      default: return CW'($urandom);
    endcase
  endfunction

  // Offers one transaction after a random gap and returns once it has been taken.
  // Valid stays high on return so that a following transaction can go back to back.
  task automatic send_item(input func_e f, input logic [CW-1:0] sx, sy, ex, ey);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i <= ex;
    end_y_i <= ey;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_item(f, sx, sy, ex, ey);
    items_in++;
  endtask

  // The endpoint fields are don't-care on an advance, so they carry random bits.
  task automatic send_advance();
    send_item(FUNC_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Stops offering, lets every owed point out, then gives the block time to go idle.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [DW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  // Writes all six registers back to back; only called while the block is idle.
  task automatic configure(input logic [1:0] count, input logic [CW-1:0] ax, ay, bx, by,
                           input logic [FW-1:0] step);
    cfg_write(CFG_CTRL_COUNT, DW'(count));
    cfg_write(CFG_CTRL_A_X, DW'(ax));
    cfg_write(CFG_CTRL_A_Y, DW'(ay));
    cfg_write(CFG_CTRL_B_X, DW'(bx));
    cfg_write(CFG_CTRL_B_Y, DW'(by));
    cfg_write(CFG_STEP_SIZE, DW'(step));
    cfg_we_i <= 1'b0;
    reg_ctrl_count = count;
    ctrl_ax = ax;
    ctrl_ay = ay;
    ctrl_bx = bx;
    ctrl_by = by;
    reg_step = step;
  endtask

  task automatic random_configure();
    logic [FW-1:0] step;
    case ($urandom_range(19))
      0:       step = '0;
      1:       step = FW'(1);
      2:       step = '1;
      3, 4, 5: step = FW'($urandom_range(64, 2047));
      default: step = FW'($urandom_range(2048, 65535));
    endcase
    configure(2'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              step);
  endtask

  // Defaults after reset: linear, step seven. An advance with nothing armed is dropped.
  task automatic test_reset_defaults();
    send_advance();
    send_item(FUNC_START, '0, '0, COORD_MAX, COORD_MAX);
    repeat (3) send_advance();
  endtask

  // Every curve order at extreme coordinates, plus the odd step and count encodings.
  task automatic test_corner_curves();
    // A step just short of one ends the curve on the second point; the third advance is
    // dropped.
    wait_quiet();
    configure(2'd0, '0, '0, '0, '0, '1);
    send_item(FUNC_START, COORD_MAX, '0, '0, COORD_MAX);
    repeat (3) send_advance();
    wait_quiet();
    configure(2'd1, COORD_MAX, COORD_MAX, '0, '0, FW'(16'h8000));
    send_item(FUNC_START, '0, COORD_MAX, COORD_MAX, '0);
    repeat (2) send_advance();
    wait_quiet();
    configure(2'd2, '0, COORD_MAX, COORD_MAX, '0, FW'(21846));
    send_item(FUNC_START, '0, '0, COORD_MAX, COORD_MAX);
    repeat (3) send_advance();
    // A count of three behaves as cubic, and a zero step as a step of one.
    wait_quiet();
    configure(2'd3, COORD_MAX, '0, '0, COORD_MAX, '0);
    send_item(FUNC_START, COORD_MAX, COORD_MAX, '0, '0);
    repeat (2) send_advance();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so the
  // output register and the internal point both fill and the input channel stalls.
  task automatic test_output_backpressure();
    int unsigned saved_pct;
    wait_quiet();
    configure(2'd2, rand_coord(), rand_coord(), rand_coord(), rand_coord(), FW'(1500));
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    send_item(FUNC_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    repeat (12) send_advance();
    send_idle_pct = saved_pct;
    wait_quiet();
  endtask

  // Mostly whole curves with random content; some cut short, some overrun, some noise.
  task automatic run_random_phase(input int unsigned send_pct, recv_pct, n);
    int unsigned   goal, pts, adv;
    logic [FW-1:0] inc;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = useful_items + n;
    while (useful_items < goal) begin
      if ($urandom_range(5) == 0) begin
        wait_quiet();
        random_configure();
      end
      if ($urandom_range(9) == 0) begin
        send_item(func_e'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord());
      end else begin
        send_item(FUNC_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        inc = (reg_step == '0) ? FW'(1) : reg_step;
        pts = int'((T_ONE + 64'(inc) - 64'd1) / 64'(inc));
        case ($urandom_range(9))
          0:       adv = $urandom_range(1, pts);
          1:       adv = pts + $urandom_range(1, 3);
          default: adv = pts;
        endcase
        if (adv > MAX_ADVANCES) adv = MAX_ADVANCES;
        repeat (adv) send_advance();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(27, 69, 300);
    wait_quiet();
    run_random_phase(69, 27, 300);
    wait_quiet();
    run_random_phase(0, 0, 300);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 27;
    recv_idle_pct = 69;
    test_reset_defaults();
    test_corner_curves();
    test_output_backpressure();
    test_random_traffic();
    wait_quiet();
    $display("Run covered %0d input transactions and %0d points, %0d of them curve ends,",
             items_in, results_out, curve_ends);
    $display("with %0d register writes over linear, quadratic and cubic curves.", cfg_writes);
    if (fail_count == 0) begin
      $display("** bezier_curve_point_stepper: PASSED **");
    end else begin
      $display("** bezier_curve_point_stepper: FAILED **");
    end
    $finish;
  end

endmodule
